// File: design/keyword_score_smoother_trigger_core_assert.svh
// Assertion macros used by the checker file of the keyword score smoother.
`ifndef KEYWORD_SCORE_SMOOTHER_TRIGGER_CORE_ASSERT_SVH
`define KEYWORD_SCORE_SMOOTHER_TRIGGER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define KSST_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define KSST_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/ksst_pkg.sv
// Package of the keyword score smoother: widths, constants, register codes and types.
`default_nettype none

package ksst_pkg;

  localparam int KEYWORD_W = 4;
  localparam int PROB_W    = 16;
  localparam int SCORE_W   = 16;
  localparam int RUN_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam int MAX_KEYWORDS_DEFAULT = 16;

  // The old weight is 65536 minus the new weight, so the average is folded
  // into a single multiply of the difference.
  localparam logic [15:0] EMA_NEW_WEIGHT = 16'd19661;
  localparam logic signed [32:0] EMA_ROUND = 33'sd32768;

  localparam logic [SCORE_W-1:0] THRESHOLD_RESET = 16'd52429;
  localparam logic [RUN_W-1:0]   MIN_RUN_RESET   = 8'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RUN   = 2'd1;

  typedef struct packed {
    logic               hit;
    logic [SCORE_W-1:0] score;
    logic [RUN_W-1:0]   run;
  } result_t;

endpackage

`default_nettype wire

// File: design/ksst_store.sv
// Per-keyword score and run counter store, cleared by reset.
`default_nettype none

module ksst_store #(
  parameter int DEPTH = ksst_pkg::MAX_KEYWORDS_DEFAULT,
  parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [IDX_W-1:0]             idx,
  output logic      [ksst_pkg::SCORE_W-1:0] rd_score,
  output logic      [ksst_pkg::RUN_W-1:0]   rd_run,
  input  wire logic                         wr_en,
  input  wire logic [ksst_pkg::SCORE_W-1:0] wr_score,
  input  wire logic [ksst_pkg::RUN_W-1:0]   wr_run
);

  logic [ksst_pkg::SCORE_W-1:0] score_r [DEPTH];
  logic [ksst_pkg::RUN_W-1:0]   run_r   [DEPTH];
  logic                         idx_ok;

  assign idx_ok = (32'(idx) < DEPTH);

  always_comb begin
    rd_score = '0;
    rd_run   = '0;
    if (idx_ok) begin
      rd_score = score_r[idx];
      rd_run   = run_r[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        score_r[i] <= '0;
        run_r[i]   <= '0;
      end
    end else if (wr_en && idx_ok) begin
      score_r[idx] <= wr_score;
      run_r[idx]   <= wr_run;
    end
  end

endmodule

`default_nettype wire

// File: design/ksst_update.sv
// Moving-average update, threshold compare and run counter for one item.
`default_nettype none

module ksst_update (
  input  wire logic                         in_range,
  input  wire logic [ksst_pkg::PROB_W-1:0]  prob,
  input  wire logic [ksst_pkg::SCORE_W-1:0] old_score,
  input  wire logic [ksst_pkg::RUN_W-1:0]   old_run,
  input  wire logic [ksst_pkg::SCORE_W-1:0] threshold,
  input  wire logic [ksst_pkg::RUN_W-1:0]   min_run,
  output ksst_pkg::result_t                 result
);

  logic signed [16:0] diff;
  logic signed [32:0] prod;
  logic signed [32:0] rounded;
  logic signed [16:0] step;
  logic signed [17:0] sum;
  logic [ksst_pkg::SCORE_W-1:0] score;
  logic [8:0]                   run_inc;
  logic [ksst_pkg::RUN_W-1:0]   run_sat;
  logic                         above;

  // new = old + ((prob - old) * w + half) >> 16, with an arithmetic shift.
  assign diff    = $signed({1'b0, prob}) - $signed({1'b0, old_score});
  assign prod    = 33'(diff) * 33'($signed({1'b0, ksst_pkg::EMA_NEW_WEIGHT}));
  assign rounded = prod + ksst_pkg::EMA_ROUND;
  assign step    = rounded[32:16];
  assign sum     = 18'($signed({1'b0, old_score})) + 18'(step);
  assign score   = sum[ksst_pkg::SCORE_W-1:0];

  assign above   = (score > threshold);
  assign run_inc = {1'b0, old_run} + 9'd1;
  assign run_sat = run_inc[8] ? {ksst_pkg::RUN_W{1'b1}} : run_inc[7:0];

  always_comb begin
    result = '0;
    if (in_range) begin
      result.score = score;
      if (above) begin
        result.run = run_sat;
        result.hit = (run_sat >= min_run);
      end
    end
  end

endmodule

`default_nettype wire

// File: design/keyword_score_smoother_trigger_core.sv
// Top level of the keyword score smoother and trigger.
//
// Each item carries a keyword index and that keyword's model posterior as
// an unsigned Q0.16 fraction. The keyword's score is updated by a 0.7/0.3
// exponential moving average with rounding; if the new score is strictly
// above the threshold register the keyword's run counter counts up
// (saturating at 255), otherwise it clears. Once the counter reaches
// min_run the result reports a detection together with a model reset
// request, and that keyword's score and counter return to zero. Every item
// produces exactly one result; an index at or beyond MAX_KEYWORDS leaves
// all state alone and returns zeros with the index echoed. The block takes
// one item per clock cycle: the input register feeds a read-modify-write
// of the per-keyword store, which is updated at the same edge that loads
// the result register, so the next item always sees the previous one's
// update. An accepted item passes through the input register and then the
// result register, which presents its result on the outputs. A waiting
// result still lets one further item into the input register; the input
// stalls only while both registers are full and the result is not being
// taken. Both stores are cleared by reset. Configuration writes take
// effect at once and are always ready; they should only be issued while no
// item is in flight. Register 0 is the threshold, register 1 is min_run
// (low eight bits of the write data); other indices are ignored.
`default_nettype none

module keyword_score_smoother_trigger_core #(
  parameter int MAX_KEYWORDS = ksst_pkg::MAX_KEYWORDS_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,

  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [ksst_pkg::KEYWORD_W-1:0]  in_keyword,
  input  wire logic [ksst_pkg::PROB_W-1:0]     in_prob,

  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 out_detected,
  output logic      [ksst_pkg::KEYWORD_W-1:0]  out_keyword_out,
  output logic      [ksst_pkg::SCORE_W-1:0]    out_smoothed,
  output logic      [ksst_pkg::RUN_W-1:0]      out_run_length,
  output logic                                 out_model_reset,

  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [ksst_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ksst_pkg::CFG_DATA_W-1:0] cfg_data
);

  // Only indices the keyword field can carry need storage.
  localparam int KW_SPAN = 1 << ksst_pkg::KEYWORD_W;
  localparam int DEPTH   = (MAX_KEYWORDS < KW_SPAN) ? MAX_KEYWORDS : KW_SPAN;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Configuration registers.
  logic [ksst_pkg::SCORE_W-1:0] threshold_r;
  logic [ksst_pkg::RUN_W-1:0]   min_run_r;

  // Input register stage.
  logic                            s1_valid_r, s1_valid_nxt;
  logic [ksst_pkg::KEYWORD_W-1:0]  s1_keyword_r;
  logic [ksst_pkg::PROB_W-1:0]     s1_prob_r;

  // Result register stage.
  logic                            out_valid_r, out_valid_nxt;
  ksst_pkg::result_t               out_result_r;
  logic [ksst_pkg::KEYWORD_W-1:0]  out_keyword_r;

  logic                            in_fire;
  logic                            s2_load;
  logic                            in_range;
  logic [IDX_W-1:0]                idx;
  logic [ksst_pkg::SCORE_W-1:0]    old_score;
  logic [ksst_pkg::RUN_W-1:0]      old_run;
  ksst_pkg::result_t               result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= ksst_pkg::THRESHOLD_RESET;
      min_run_r   <= ksst_pkg::MIN_RUN_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        ksst_pkg::CFG_THRESHOLD: threshold_r <= cfg_data;
        ksst_pkg::CFG_MIN_RUN:   min_run_r   <= cfg_data[ksst_pkg::RUN_W-1:0];
        default: ;
      endcase
    end
  end

  // The item in the input register moves on whenever the result register
  // is empty or is being emptied this cycle; the store is written then too for an in-range index.
  assign s2_load  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s2_load;
  assign in_fire  = in_valid && in_ready;

  assign s1_valid_nxt  = in_fire ? 1'b1 : (s2_load ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s2_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_keyword_r <= in_keyword;
      s1_prob_r    <= in_prob;
    end
    if (s2_load) begin
      out_result_r  <= result;
      out_keyword_r <= s1_keyword_r;
    end
  end

  assign in_range = (32'(s1_keyword_r) < MAX_KEYWORDS);
  assign idx      = s1_keyword_r[IDX_W-1:0];

  ksst_store #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .idx      (idx),
    .rd_score (old_score),
    .rd_run   (old_run),
    .wr_en    (s2_load && in_range),
    .wr_score (result.hit ? '0 : result.score),
    .wr_run   (result.hit ? '0 : result.run)
  );

  ksst_update u_update (
    .in_range  (in_range),
    .prob      (s1_prob_r),
    .old_score (old_score),
    .old_run   (old_run),
    .threshold (threshold_r),
    .min_run   (min_run_r),
    .result    (result)
  );

  assign out_valid       = out_valid_r;
  assign out_detected    = out_result_r.hit;
  assign out_model_reset = out_result_r.hit;
  assign out_keyword_out = out_keyword_r;
  assign out_smoothed    = out_result_r.score;
  assign out_run_length  = out_result_r.run;

endmodule

`default_nettype wire

// File: design/ksst_checker.sv
// Port-level checker for the keyword score smoother, bound to the top level.
`default_nettype none

`include "keyword_score_smoother_trigger_core_assert.svh"

module ksst_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic                         out_detected,
  input wire logic                         out_model_reset,
  input wire logic [ksst_pkg::SCORE_W-1:0] out_smoothed,
  input wire logic [ksst_pkg::RUN_W-1:0]   out_run_length
);

  `KSST_ASSERT_IMP(a_reset_req_matches, clk, rst_n, out_valid, out_detected == out_model_reset, "model reset request differs from detection")
  `KSST_ASSERT_IMP(a_detect_needs_run, clk, rst_n, out_valid && out_detected, (out_run_length != '0) && (out_smoothed != '0), "detection without a run or a score")
  `KSST_ASSERT_NXT(a_result_held, clk, rst_n, out_valid && !out_ready, out_valid, "result item dropped while stalled")
  `KSST_ASSERT_NXT(a_payload_held, clk, rst_n, out_valid && !out_ready, $stable(out_smoothed) && $stable(out_run_length) && $stable(out_detected), "stalled result item changed")

endmodule

bind keyword_score_smoother_trigger_core ksst_checker u_ksst_checker (.*);

`default_nettype wire
